>>> sv/fsrl_pkg.sv
// ---------------------------------------------------------------------------
// Frame slot ring lease manager package
// Shared item types, operation codes, status codes and cell interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package fsrl_pkg;

  // wide enough to hold a slot count up to 16
  localparam int unsigned N_W = 5;

  typedef enum logic [2:0] {
    KIND_PUBLISH_NEXT     = 3'd0,
    KIND_PUBLISH_RESERVED = 3'd1,
    KIND_TAKE_CURSOR      = 3'd2,
    KIND_SET_CURSOR_AFTER = 3'd3,
    KIND_FIND_FREE        = 3'd4,
    KIND_ACQUIRE          = 3'd5,
    KIND_RELEASE          = 3'd6,
    KIND_QUERY_LEASED     = 3'd7
  } kind_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;
  localparam logic [1:0] STATUS_SATURATED = 2'd3;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } fsm_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] slot;
    logic [7:0] ready_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  slot_out;
    logic [63:0] serial;
    logic [1:0]  status;
    logic        leased;
  } out_item_t;

  typedef struct packed {
    logic lease_inc;
    logic lease_dec;
    logic tok_load;
    logic tok_start;
    logic tok_shift;
    logic cand_ok;
  } cell_ctrl_t;

  typedef struct packed {
    logic tok;
    logic hit;
    logic lease_zero;
    logic lease_max;
  } cell_stat_t;

endpackage

`default_nettype wire

>>> sv/fsrl_cell.sv
// ---------------------------------------------------------------------------
// Slot cell
// Holds one slot's lease count and one stage of the circulating search token.
// ---------------------------------------------------------------------------
`default_nettype none

module fsrl_cell
  import fsrl_pkg::*;
#(
  parameter int unsigned LEASE_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       tok_in,
  output cell_stat_t      stat
);

  logic [LEASE_BITS-1:0] lease_r, lease_nxt;
  logic                  tok_r, tok_nxt;

  always_comb begin
    lease_nxt = lease_r;
    if (ctrl.lease_inc) begin
      lease_nxt = lease_r + LEASE_BITS'(1);
    end else if (ctrl.lease_dec) begin
      lease_nxt = lease_r - LEASE_BITS'(1);
    end
  end

  always_comb begin
    tok_nxt = tok_r;
    if (ctrl.tok_load) begin
      tok_nxt = ctrl.tok_start;
    end else if (ctrl.tok_shift) begin
      tok_nxt = tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lease_r <= '0;
      tok_r   <= 1'b0;
    end else begin
      lease_r <= lease_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign stat.tok        = tok_r;
  assign stat.lease_zero = (lease_r == '0);
  assign stat.lease_max  = (lease_r == '1);
  // token sits here and this slot may be reused
  assign stat.hit        = tok_r & ctrl.cand_ok & (lease_r == '0);

endmodule

`default_nettype wire

>>> sv/frame_slot_ring_lease_manager.sv
// ---------------------------------------------------------------------------
// Frame slot ring lease manager
// Ring of frame slots with lease counts, cursor, publish serial and a
// round-robin free-slot search carried by a token through a row of slot cells.
// ---------------------------------------------------------------------------
// Results: every operation but find_free gives its result in the cycle after
//   the transfer; find_free answers when its scan ends, as the search token
//   steps one cell per cycle around the n slots in use.
// Throughput: one item per cycle, except that busy stays high during a scan.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset: lease counts, cursor, serial and publish record clear; slots_in_use=8.
// ---------------------------------------------------------------------------
`default_nettype none

module frame_slot_ring_lease_manager
  import fsrl_pkg::*;
#(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned LEASE_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data,
  output logic            out_valid,
  output out_item_t       out_item
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [N_W-1:0] SLOTS_N = N_W'(SLOTS);

  fsm_state_t        state_r, state_nxt;
  logic [3:0]        cfg_r;
  logic [IDX_W-1:0]  cursor_r, cursor_nxt;
  logic [3:0]        pub_slot_r, pub_slot_nxt;
  logic              pub_valid_r, pub_valid_nxt;
  logic [63:0]       serial_r, serial_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic [N_W-1:0]    steps_r, steps_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [N_W-1:0]    live_n;
  logic              accept, in_range;
  logic [IDX_W-1:0]  sel_idx, hit_idx, wrap_idx;
  logic [N_W-1:0]    cur_eff, cur_inc, slot_inc;
  logic              any_hit, scan_last;

  cell_ctrl_t        ctrl [SLOTS];
  cell_stat_t        stat [SLOTS];
  logic [SLOTS-1:0]  tok_vec, hit_vec, lz_vec, lmax_vec, ready_vec;

  assign live_n    = ({1'b0, cfg_r} > SLOTS_N) ? SLOTS_N : {1'b0, cfg_r};
  assign accept    = start && !busy;
  assign in_range  = (live_n != '0) && ({1'b0, in_item.slot} < live_n);
  assign sel_idx   = in_item.slot[IDX_W-1:0];
  assign wrap_idx  = IDX_W'(live_n - N_W'(1));
  assign any_hit   = |hit_vec;
  assign scan_last = (steps_r == live_n - N_W'(1));
  assign cur_eff   = ({{(N_W-IDX_W){1'b0}}, cursor_r} < live_n) ?
                     {{(N_W-IDX_W){1'b0}}, cursor_r} : '0;
  assign cur_inc   = (cur_eff + N_W'(1) == live_n) ? '0 : cur_eff + N_W'(1);
  assign slot_inc  = ({1'b0, in_item.slot} + N_W'(1) == live_n) ? '0 :
                     {1'b0, in_item.slot} + N_W'(1);

  // row of slot cells; token wraps from the last live cell to cell 0
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic tok_in;
    logic ready_bit;
    if (i == 0) begin : g_head
      assign tok_in = tok_vec[wrap_idx];
    end else begin : g_link
      // cells past the live ring never pick up the token
      assign tok_in = tok_vec[i-1] & (N_W'(i) < live_n);
    end
    if (i < 8) begin : g_mask
      assign ready_bit = mask_r[i];
    end else begin : g_nomask
      assign ready_bit = 1'b0;
    end

    fsrl_cell #(
      .LEASE_BITS(LEASE_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl[i]),
      .tok_in (tok_in),
      .stat   (stat[i])
    );

    assign tok_vec[i]   = stat[i].tok;
    assign hit_vec[i]   = stat[i].hit;
    assign lz_vec[i]    = stat[i].lease_zero;
    assign lmax_vec[i]  = stat[i].lease_max;
    assign ready_vec[i] = ready_bit;
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_vec[i]) hit_idx = IDX_W'(i);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_item.kind == KIND_FIND_FREE && in_range) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (any_hit || scan_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and cell control
  always_comb begin
    cursor_nxt    = cursor_r;
    pub_slot_nxt  = pub_slot_r;
    pub_valid_nxt = pub_valid_r;
    serial_nxt    = serial_r;
    mask_nxt      = mask_r;
    steps_nxt     = steps_r;
    out_nxt       = '0;
    out_valid_nxt = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      ctrl[i].lease_inc = 1'b0;
      ctrl[i].lease_dec = 1'b0;
      ctrl[i].tok_load  = 1'b0;
      ctrl[i].tok_start = 1'b0;
      ctrl[i].tok_shift = 1'b0;
      ctrl[i].cand_ok   = (N_W'(i) < live_n) && ready_vec[i] &&
                          !(pub_valid_r && pub_slot_r == 4'(i));
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_item.kind)
            KIND_PUBLISH_NEXT, KIND_PUBLISH_RESERVED: begin
              if (in_item.kind == KIND_PUBLISH_NEXT) out_nxt.serial = serial_r;
              serial_nxt    = serial_r + 64'd1;
              pub_slot_nxt  = in_item.slot;
              pub_valid_nxt = 1'b1;
            end
            KIND_TAKE_CURSOR: begin
              if (live_n == '0) begin
                out_nxt.status = STATUS_NO_SLOT;
              end else begin
                out_nxt.slot_out = cur_eff[2:0];
                cursor_nxt       = IDX_W'(cur_inc);
              end
            end
            KIND_SET_CURSOR_AFTER: begin
              if (!in_range) out_nxt.status = STATUS_NO_SLOT;
              else cursor_nxt = IDX_W'(slot_inc);
            end
            KIND_FIND_FREE: begin
              if (!in_range) begin
                out_nxt.status = STATUS_NO_SLOT;
              end else begin
                // result comes at the end of the scan
                out_valid_nxt = 1'b0;
                mask_nxt      = in_item.ready_mask;
                steps_nxt     = '0;
                for (int i = 0; i < SLOTS; i++) begin
                  ctrl[i].tok_load  = 1'b1;
                  ctrl[i].tok_start = (IDX_W'(i) == sel_idx);
                end
              end
            end
            KIND_ACQUIRE: begin
              if (!in_range) out_nxt.status = STATUS_NO_SLOT;
              else if (lmax_vec[sel_idx]) out_nxt.status = STATUS_SATURATED;
              else ctrl[sel_idx].lease_inc = 1'b1;
            end
            KIND_RELEASE: begin
              if (!in_range) out_nxt.status = STATUS_NO_SLOT;
              else if (lz_vec[sel_idx]) out_nxt.status = STATUS_UNDERFLOW;
              else ctrl[sel_idx].lease_dec = 1'b1;
            end
            KIND_QUERY_LEASED: begin
              if (!in_range) out_nxt.status = STATUS_NO_SLOT;
              else out_nxt.leased = !lz_vec[sel_idx];
            end
            default: out_nxt = '0;
          endcase
        end
      end
      S_SCAN: begin
        if (any_hit) begin
          out_valid_nxt    = 1'b1;
          out_nxt.slot_out = 3'(hit_idx);
          for (int i = 0; i < SLOTS; i++) ctrl[i].tok_load = 1'b1;
        end else if (scan_last) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = STATUS_NO_SLOT;
          for (int i = 0; i < SLOTS; i++) ctrl[i].tok_load = 1'b1;
        end else begin
          steps_nxt = steps_r + N_W'(1);
          for (int i = 0; i < SLOTS; i++) ctrl[i].tok_shift = 1'b1;
        end
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= 4'd8;
      cursor_r    <= '0;
      pub_slot_r  <= '0;
      pub_valid_r <= 1'b0;
      serial_r    <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) cfg_r <= cfg_data;
      cursor_r    <= cursor_nxt;
      pub_slot_r  <= pub_slot_nxt;
      pub_valid_r <= pub_valid_nxt;
      serial_r    <= serial_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r == S_SCAN);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // a result never shows while a scan is still running
  a_no_out_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe during scan");

  // exactly one token circulates while scanning
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $onehot(tok_vec))
    else $error("scan token lost or duplicated");

  a_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (tok_vec == '0))
    else $error("stray token while idle");

  // everything but an in-range find_free answers in the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind != KIND_FIND_FREE) |=> out_valid)
    else $error("missing one-cycle result");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (steps_r < live_n))
    else $error("scan ran past ring length");

endmodule

`default_nettype wire

>>> test/tb_frame_slot_ring_lease_manager.sv
// ---------------------------------------------------------------------------
// Frame slot ring lease manager testbench
// Drives slot ring operations through the start/busy port and predicts
// every result from a local copy of the ring state. Results are checked in
// order, field by field. The slot count register is rewritten between phases
// while the ring is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_frame_slot_ring_lease_manager;
  import fsrl_pkg::*;

  localparam int unsigned RING_SLOTS = 8;
  localparam int unsigned LEASE_W    = 8;
  localparam logic [7:0]  LEASE_TOP  = 8'hFF;
  localparam int          STALL_LIMIT = 400;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  in_item_t   in_item   = '0;
  logic       cfg_valid = 1'b0;
  logic [3:0] cfg_data  = 4'd0;
  logic       busy;
  logic       cfg_ready;
  logic       out_valid;
  out_item_t  out_item;

  frame_slot_ring_lease_manager #(
    .SLOTS      (RING_SLOTS),
    .LEASE_BITS (LEASE_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // local ring state
  logic [7:0]  lease_tally [RING_SLOTS];
  logic [2:0]  ring_cursor   = 3'd0;
  logic [3:0]  pub_slot      = 4'd0;
  logic        pub_valid     = 1'b0;
  logic [63:0] serial_next   = 64'd0;
  logic [3:0]  slot_count    = 4'd8;

  in_item_t  ops_to_issue [$];
  out_item_t due_results  [$];
  out_item_t due_now;
  int        fault_count = 0;
  int        idle_left   = 0;
  int        stall_count = 0;
  bit        gaps_on     = 1'b1;

  initial begin
    for (int i = 0; i < RING_SLOTS; i++) lease_tally[i] = 8'd0;
  end

  function automatic int unsigned live_slots();
    return (slot_count > 4'd8) ? RING_SLOTS : int'(slot_count);
  endfunction

  // apply one operation to the local ring state and return its result
  function automatic out_item_t ring_outcome(in_item_t op);
    out_item_t   r;
    int unsigned live;
    int unsigned slot_n;
    int unsigned cand;
    int unsigned next_c;
    bit          in_range;
    bit          found;
    r        = '0;
    r.status = STATUS_OK;
    live     = live_slots();
    slot_n   = int'(op.slot);
    in_range = (live != 0) && (slot_n < live);
    found    = 1'b0;
    case (op.kind)
      KIND_PUBLISH_NEXT, KIND_PUBLISH_RESERVED: begin
        if (op.kind == KIND_PUBLISH_NEXT) r.serial = serial_next;
        serial_next = serial_next + 64'd1;
        pub_slot    = op.slot;
        pub_valid   = 1'b1;
      end
      KIND_TAKE_CURSOR: begin
        if (live == 0) begin
          r.status = STATUS_NO_SLOT;
        end else begin
          // cursor left beyond a shrunk ring restarts at slot zero
          next_c      = (int'(ring_cursor) < live) ? int'(ring_cursor) : 0;
          r.slot_out  = next_c[2:0];
          next_c      = (next_c + 1) % live;
          ring_cursor = next_c[2:0];
        end
      end
      KIND_SET_CURSOR_AFTER: begin
        if (!in_range) begin
          r.status = STATUS_NO_SLOT;
        end else begin
          next_c      = (slot_n + 1) % live;
          ring_cursor = next_c[2:0];
        end
      end
      KIND_FIND_FREE: begin
        r.status = STATUS_NO_SLOT;
        if (in_range) begin
          for (int unsigned k = 0; k < live; k++) begin
            cand = (slot_n + k) % live;
            if (!found && !(pub_valid && cand == int'(pub_slot)) &&
                lease_tally[cand] == 8'd0 && op.ready_mask[cand]) begin
              found      = 1'b1;
              r.slot_out = cand[2:0];
              r.status   = STATUS_OK;
            end
          end
        end
      end
      KIND_ACQUIRE: begin
        if (!in_range) r.status = STATUS_NO_SLOT;
        else if (lease_tally[slot_n] == LEASE_TOP) r.status = STATUS_SATURATED;
        else lease_tally[slot_n] = lease_tally[slot_n] + 8'd1;
      end
      KIND_RELEASE: begin
        if (!in_range) r.status = STATUS_NO_SLOT;
        else if (lease_tally[slot_n] == 8'd0) r.status = STATUS_UNDERFLOW;
        else lease_tally[slot_n] = lease_tally[slot_n] - 8'd1;
      end
      default: begin
        if (!in_range) r.status = STATUS_NO_SLOT;
        else r.leased = (lease_tally[slot_n] != 8'd0);
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t make_op(kind_t k, logic [3:0] s, logic [7:0] m);
    in_item_t op;
    op.kind       = k;
    op.slot       = s;
    op.ready_mask = m;
    return op;
  endfunction

  function automatic in_item_t random_op();
    int unsigned live;
    int unsigned pick;
    kind_t       k;
    logic [3:0]  s;
    logic [7:0]  m;
    live = live_slots();
    pick = $urandom_range(0, 99);
    if (pick < 8) k = KIND_PUBLISH_NEXT;
    else if (pick < 12) k = KIND_PUBLISH_RESERVED;
    else if (pick < 22) k = KIND_TAKE_CURSOR;
    else if (pick < 30) k = KIND_SET_CURSOR_AFTER;
    else if (pick < 52) k = KIND_FIND_FREE;
    else if (pick < 72) k = KIND_ACQUIRE;
    else if (pick < 88) k = KIND_RELEASE;
    else k = KIND_QUERY_LEASED;
    // mostly slots inside the ring, now and then anything the field holds
    if (live == 0 || $urandom_range(0, 9) == 0) s = 4'($urandom_range(0, 15));
    else s = 4'($urandom_range(0, live - 1));
    case ($urandom_range(0, 7))
      0: m = 8'hFF;
      1: m = 8'h00;
      default: m = 8'($urandom);
    endcase
    return make_op(k, s, m);
  endfunction

  task automatic wait_drained();
    while (ops_to_issue.size() != 0 || start || due_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_slot_count(input logic [3:0] count);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_data  <= count;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    slot_count = count;
    cfg_valid <= 1'b0;
  endtask

  // a phase opens on take_cursor (stale cursor after a shrink) and leaves
  // the cursor near the top of the ring for the next one
  task automatic queue_phase(input int n);
    int unsigned live;
    live = live_slots();
    @(negedge clk);
    ops_to_issue.push_back(make_op(KIND_TAKE_CURSOR, 4'd0, 8'h00));
    for (int i = 0; i < n - 2; i++) ops_to_issue.push_back(random_op());
    ops_to_issue.push_back(make_op(KIND_SET_CURSOR_AFTER,
                                   (live >= 2) ? 4'(live - 2) : 4'd0, 8'h00));
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fault_count++;
    end
  endtask

  // driver: one transfer per start && !busy edge
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) due_results.push_back(ring_outcome(in_item));
      if (start && busy) begin
        // item held until taken
      end else if (idle_left > 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
      end else if (ops_to_issue.size() != 0 && gaps_on && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(0, 14);
        start <= 1'b0;
      end else if (ops_to_issue.size() != 0) begin
        in_item <= ops_to_issue.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, out_item);
        fault_count++;
      end else begin
        due_now = due_results.pop_front();
        check_field("slot_out", 64'(due_now.slot_out), 64'(out_item.slot_out));
        check_field("serial",   due_now.serial,        out_item.serial);
        check_field("status",   64'(due_now.status),   64'(out_item.status));
        check_field("leased",   64'(due_now.leased),   64'(out_item.leased));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    logic [3:0] counts [12];
    logic [3:0] storm_slot;
    counts = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2, 4'd10, 4'd7, 4'd4,
               4'd6, 4'd8};
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, ring of eight right after reset
    ops_to_issue.push_back(make_op(KIND_QUERY_LEASED,     4'd0,  8'h00));
    ops_to_issue.push_back(make_op(KIND_FIND_FREE,        4'd0,  8'h00));
    ops_to_issue.push_back(make_op(KIND_FIND_FREE,        4'd5,  8'hFF));
    ops_to_issue.push_back(make_op(KIND_PUBLISH_NEXT,     4'd15, 8'h00));
    ops_to_issue.push_back(make_op(KIND_PUBLISH_NEXT,     4'd2,  8'hFF));
    ops_to_issue.push_back(make_op(KIND_PUBLISH_RESERVED, 4'd5,  8'h00));
    ops_to_issue.push_back(make_op(KIND_PUBLISH_NEXT,     4'd5,  8'h00));
    ops_to_issue.push_back(make_op(KIND_FIND_FREE,        4'd4,  8'hFF));
    ops_to_issue.push_back(make_op(KIND_FIND_FREE,        4'd5,  8'hFF));
    ops_to_issue.push_back(make_op(KIND_FIND_FREE,        4'd7,  8'h01));
    ops_to_issue.push_back(make_op(KIND_ACQUIRE,          4'd6,  8'h00));
    ops_to_issue.push_back(make_op(KIND_ACQUIRE,          4'd15, 8'h00));
    ops_to_issue.push_back(make_op(KIND_RELEASE,          4'd6,  8'h00));
    ops_to_issue.push_back(make_op(KIND_RELEASE,          4'd6,  8'h00));
    ops_to_issue.push_back(make_op(KIND_ACQUIRE,          4'd7,  8'h00));
    ops_to_issue.push_back(make_op(KIND_QUERY_LEASED,     4'd7,  8'h00));
    ops_to_issue.push_back(make_op(KIND_FIND_FREE,        4'd7,  8'hC0));
    ops_to_issue.push_back(make_op(KIND_QUERY_LEASED,     4'd12, 8'h00));
    ops_to_issue.push_back(make_op(KIND_TAKE_CURSOR,      4'd0,  8'h00));
    ops_to_issue.push_back(make_op(KIND_TAKE_CURSOR,      4'd0,  8'h00));
    ops_to_issue.push_back(make_op(KIND_SET_CURSOR_AFTER, 4'd7,  8'h00));
    ops_to_issue.push_back(make_op(KIND_TAKE_CURSOR,      4'd0,  8'h00));
    ops_to_issue.push_back(make_op(KIND_SET_CURSOR_AFTER, 4'd8,  8'h00));
    ops_to_issue.push_back(make_op(KIND_SET_CURSOR_AFTER, 4'd3,  8'h00));
    wait_drained();

    // lease storm: drive one slot to saturation, then past zero
    storm_slot = 4'($urandom_range(0, 7));
    for (int i = 0; i < 257; i++) begin
      if ($urandom_range(0, 15) == 0) ops_to_issue.push_back(random_op());
      ops_to_issue.push_back(make_op(KIND_ACQUIRE, storm_slot, 8'($urandom)));
    end
    ops_to_issue.push_back(make_op(KIND_QUERY_LEASED, storm_slot, 8'h00));
    for (int i = 0; i < 258; i++) begin
      if ($urandom_range(0, 15) == 0) ops_to_issue.push_back(random_op());
      ops_to_issue.push_back(make_op(KIND_RELEASE, storm_slot, 8'($urandom)));
    end

    foreach (counts[p]) begin
      write_slot_count(counts[p]);
      gaps_on = (p < 10) && (p != 6);
      queue_phase(int'($urandom_range(70, 110)));
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
